@@ hdl/nll_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nll_pkg
// Shared types, codes and constants of the numeric literal lexer.
// ----------------------------------------------------------------------------
package nll_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
    localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] STATUS_CLEAN = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_MAL   = 2'd2;

    localparam logic [2:0] KIND_ZERO  = 3'd0;
    localparam logic [2:0] KIND_OCTAL = 3'd1;
    localparam logic [2:0] KIND_HEX   = 3'd2;
    localparam logic [2:0] KIND_DEC   = 3'd3;
    localparam logic [2:0] KIND_FLOAT = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] token_kind;
        logic [7:0] token_length;
    } t_out_item;

    // character class of one item
    typedef struct packed {
        logic is_zero;
        logic is_oct;
        logic is_dig;
        logic is_hex;
        logic is_x;
        logic is_dot;
        logic is_exp;
        logic is_sign;
        logic is_ws;
        logic last;
    } t_cls;

    typedef struct packed {
        logic push;
        t_cls data;
    } t_push;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage

@@ hdl/nll_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nll_front
// Accepts characters and turns each into a character class for the queue.
// ----------------------------------------------------------------------------
module nll_front (
    input  logic              i_valid,
    input  nll_pkg::t_in_item i_item,
    input  nll_pkg::t_q_stat  i_q_stat,
    output logic              o_stall,
    output nll_pkg::t_push    o_push
);

    logic [7:0] c;

    assign c = i_item.char_code;

    always_comb begin
        o_push.data.is_zero = (c == 8'h30);
        o_push.data.is_oct  = (c >= 8'h30) && (c <= 8'h37);
        o_push.data.is_dig  = (c >= 8'h30) && (c <= 8'h39);
        o_push.data.is_hex  = ((c >= 8'h30) && (c <= 8'h39))
                            || ((c >= 8'h61) && (c <= 8'h66))
                            || ((c >= 8'h41) && (c <= 8'h46));
        o_push.data.is_x    = (c == 8'h78) || (c == 8'h58);
        o_push.data.is_dot  = (c == 8'h2e);
        o_push.data.is_exp  = (c == 8'h65) || (c == 8'h45);
        o_push.data.is_sign = (c == 8'h2b) || (c == 8'h2d);
        o_push.data.is_ws   = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
        o_push.data.last    = i_item.last_char;
        o_push.push         = i_valid && !i_q_stat.full;
    end

    assign o_stall = i_q_stat.full;

endmodule

@@ hdl/nll_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nll_queue
// Small fifo of classified characters between front and back.
// ----------------------------------------------------------------------------
module nll_queue #(
    parameter int DEPTH = nll_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nll_pkg::t_push   i_push,
    input  logic             i_pop,
    output nll_pkg::t_cls    o_data,
    output nll_pkg::t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    nll_pkg::t_cls r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    assign o_data           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == FULL_CNT);

endmodule

@@ hdl/nll_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nll_back
// Literal state machine: steps on each queued character, keeps the token
// length and registers the reported token.
// ----------------------------------------------------------------------------
module nll_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nll_pkg::t_cls      i_data,
    input  nll_pkg::t_q_stat   i_q_stat,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output nll_pkg::t_out_item o_item
);

    typedef enum logic [3:0] {
        S_ZERO, S_OCT, S_HEXPRE, S_HEX, S_DOTPRE, S_FRAC0, S_DEC,
        S_DOT, S_FRAC, S_EXP, S_EXPSIGN, S_EXPDIG, S_IDLE
    } t_state;

    typedef enum logic [1:0] {A_GO, A_WS, A_BAD, A_MAL} t_act;

    t_state             r_state;
    t_state             n_state;
    t_state             step_state;
    t_act               act;
    logic [7:0]         r_len;
    logic [7:0]         n_len;
    logic [7:0]         inc_len;
    logic               r_valid;
    logic               n_valid;
    nll_pkg::t_out_item r_item;
    nll_pkg::t_out_item n_item;
    logic               take;

    function automatic logic accepting(input t_state s);
        return (s == S_ZERO) || (s == S_OCT) || (s == S_HEX) || (s == S_FRAC0)
            || (s == S_DEC) || (s == S_FRAC) || (s == S_EXPDIG);
    endfunction

    function automatic logic [2:0] kind_of(input t_state s);
        logic [2:0] k;
        unique case (s)
            S_ZERO:  k = nll_pkg::KIND_ZERO;
            S_OCT:   k = nll_pkg::KIND_OCTAL;
            S_HEX:   k = nll_pkg::KIND_HEX;
            S_DEC:   k = nll_pkg::KIND_DEC;
            default: k = nll_pkg::KIND_FLOAT;
        endcase
        return k;
    endfunction

    assign take  = i_q_stat.not_empty && (!r_valid || !i_stall);
    assign o_pop = take;

    // next literal state and end of token action for the current character
    always_comb begin
        step_state = r_state;
        act        = A_GO;
        unique case (r_state)
            S_ZERO: begin
                if (i_data.is_oct)      step_state = S_OCT;
                else if (i_data.is_x)   step_state = S_HEXPRE;
                else if (i_data.is_dot) step_state = S_DOTPRE;
                else                    act = i_data.is_ws ? A_WS : A_BAD;
            end
            S_OCT: begin
                if (i_data.is_oct) step_state = S_OCT;
                else               act = i_data.is_ws ? A_WS : A_BAD;
            end
            S_HEXPRE: begin
                if (i_data.is_hex) step_state = S_HEX;
                else               act = A_MAL;
            end
            S_HEX: begin
                if (i_data.is_hex) step_state = S_HEX;
                else               act = i_data.is_ws ? A_WS : A_BAD;
            end
            S_DOTPRE: begin
                if (i_data.is_dig) step_state = S_FRAC0;
                else               act = A_MAL;
            end
            S_FRAC0: begin
                if (i_data.is_exp)      step_state = S_EXP;
                else if (i_data.is_dig) step_state = S_FRAC0;
                else                    act = i_data.is_ws ? A_WS : A_BAD;
            end
            S_DEC: begin
                if (i_data.is_dig)      step_state = S_DEC;
                else if (i_data.is_dot) step_state = S_DOT;
                else if (i_data.is_exp) step_state = S_EXP;
                else                    act = i_data.is_ws ? A_WS : A_BAD;
            end
            S_DOT: begin
                if (i_data.is_dig) step_state = S_FRAC;
                else               act = A_MAL;
            end
            S_FRAC: begin
                if (i_data.is_dig)      step_state = S_FRAC;
                else if (i_data.is_exp) step_state = S_EXP;
                else                    act = i_data.is_ws ? A_WS : A_BAD;
            end
            S_EXP: begin
                if (i_data.is_sign)     step_state = S_EXPSIGN;
                else if (i_data.is_dig) step_state = S_EXPDIG;
                else                    act = A_MAL;
            end
            S_EXPSIGN: begin
                if (i_data.is_dig) step_state = S_EXPDIG;
                else               act = A_MAL;
            end
            S_EXPDIG: begin
                if (i_data.is_dig) step_state = S_EXPDIG;
                else               act = i_data.is_ws ? A_WS : A_BAD;
            end
            default: begin
                if (i_data.is_zero)     step_state = S_ZERO;
                else if (i_data.is_dig) step_state = S_DEC;
                else                    act = i_data.is_ws ? A_WS : A_MAL;
            end
        endcase
    end

    assign inc_len = (r_len < nll_pkg::LEN_CAP) ? r_len + 8'd1 : r_len;

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_valid = r_valid && i_stall;
        n_item  = r_item;
        if (take) begin
            n_state = S_IDLE;
            n_len   = '0;
            unique case (act)
                A_MAL: begin
                    n_valid = 1'b1;
                    n_item  = '{nll_pkg::STATUS_MAL, nll_pkg::KIND_ZERO, 8'd0};
                end
                A_BAD: begin
                    n_valid = 1'b1;
                    n_item  = '{nll_pkg::STATUS_BAD, kind_of(r_state), r_len};
                end
                A_WS: begin
                    if (accepting(r_state)) begin
                        n_valid = 1'b1;
                        n_item  = '{nll_pkg::STATUS_CLEAN, kind_of(r_state), r_len};
                    end
                end
                default: begin
                    if (i_data.last) begin
                        n_valid = 1'b1;
                        if (accepting(step_state)) begin
                            n_item = '{nll_pkg::STATUS_CLEAN, kind_of(step_state),
                                       inc_len};
                        end else begin
                            n_item = '{nll_pkg::STATUS_MAL, nll_pkg::KIND_ZERO, 8'd0};
                        end
                    end else begin
                        n_state = step_state;
                        n_len   = inc_len;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/numeric_literal_lexer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_lexer_top
// Lexer for C-style numeric literals, one character per item.
// ----------------------------------------------------------------------------
// Sustains one character per clock while the queue is not full. A character
// is classified in the cycle it is accepted and written to a small queue;
// the literal state machine takes it from the queue, unless an output stall
// holds it there, and registers the token it reports as it takes it. The
// queue (QUEUE_DEPTH entries) absorbs an output stall; the input stalls
// only once it is full.
module numeric_literal_lexer_top #(
    parameter int QUEUE_DEPTH = nll_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  nll_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output nll_pkg::t_out_item o_item
);

    nll_pkg::t_push   push;
    nll_pkg::t_cls    q_data;
    nll_pkg::t_q_stat q_stat;
    logic             pop;

    nll_front u_front (
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_stall  (o_stall),
        .o_push   (push)
    );

    nll_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    nll_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (q_data),
        .i_q_stat (q_stat),
        .i_stall  (i_stall),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !push.push)
        else $error("queue written while full");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.not_empty)
        else $error("queue read while empty");

    a_mal_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status == nll_pkg::STATUS_MAL) |->
            (o_item.token_kind == nll_pkg::KIND_ZERO && o_item.token_length == 8'd0))
        else $error("malformed item carries a token");

    a_token_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status != nll_pkg::STATUS_MAL) |->
            (o_item.token_length != 8'd0 && o_item.status <= nll_pkg::STATUS_BAD))
        else $error("reported token has no characters");

endmodule

@@ tb/numeric_literal_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_checker
// Watches both channels of the lexer, predicts every token report from the
// accepted characters and compares each report field by field, in order.
// ----------------------------------------------------------------------------
module numeric_literal_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  nll_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  nll_pkg::t_out_item i_out_item,
    output int                 o_errors,
    output int                 o_pending
);
    import nll_pkg::*;

    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_7     = "7";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LF    = "f";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UF    = "F";
    localparam logic [7:0] CH_LX    = "x";
    localparam logic [7:0] CH_UX    = "X";
    localparam logic [7:0] CH_LE    = "e";
    localparam logic [7:0] CH_UE    = "E";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam int         MAX_REPORTS = 10;

    typedef enum logic [3:0] {
        LX_ZERO, LX_OCT, LX_HEXPRE, LX_HEX, LX_DOTPRE, LX_FRAC0, LX_DEC, LX_DOT,
        LX_FRAC, LX_EXP, LX_EXPSIGN, LX_EXPDIG, LX_IDLE, LX_BAD, LX_MAL, LX_WS
    } lex_state_e;

    lex_state_e  lex_st  = LX_IDLE;
    logic [7:0]  tok_len = '0;
    t_out_item   report_q[$];
    int          err_cnt = 0;

    initial o_errors  = 0;
    initial o_pending = 0;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_octal(input logic [7:0] c);
        return c >= CH_0 && c <= CH_7;
    endfunction

    function automatic bit is_hexdig(input logic [7:0] c);
        return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_expch(input logic [7:0] c);
        return c == CH_LE || c == CH_UE;
    endfunction

    function automatic bit is_accepting(input lex_state_e s);
        return s == LX_ZERO || s == LX_OCT || s == LX_HEX || s == LX_FRAC0 ||
               s == LX_DEC || s == LX_FRAC || s == LX_EXPDIG;
    endfunction

    function automatic logic [2:0] kind_of(input lex_state_e s);
        case (s)
            LX_ZERO: return KIND_ZERO;
            LX_OCT:  return KIND_OCTAL;
            LX_HEX:  return KIND_HEX;
            LX_DEC:  return KIND_DEC;
            default: return KIND_FLOAT;
        endcase
    endfunction

    function automatic lex_state_e next_lex(input lex_state_e s, input logic [7:0] c);
        lex_state_e end_st;
        end_st = is_space(c) ? LX_WS : LX_BAD;
        case (s)
            LX_ZERO: begin
                if (is_octal(c)) return LX_OCT;
                if (c == CH_LX || c == CH_UX) return LX_HEXPRE;
                if (c == CH_DOT) return LX_DOTPRE;
                return end_st;
            end
            LX_OCT: begin
                if (is_octal(c)) return LX_OCT;
                return end_st;
            end
            LX_HEXPRE: return is_hexdig(c) ? LX_HEX : LX_MAL;
            LX_HEX: begin
                if (is_hexdig(c)) return LX_HEX;
                return end_st;
            end
            LX_DOTPRE: return is_digit(c) ? LX_FRAC0 : LX_MAL;
            LX_FRAC0: begin
                if (is_expch(c)) return LX_EXP;
                if (is_digit(c)) return LX_FRAC0;
                return end_st;
            end
            LX_DEC: begin
                if (is_digit(c)) return LX_DEC;
                if (c == CH_DOT) return LX_DOT;
                if (is_expch(c)) return LX_EXP;
                return end_st;
            end
            LX_DOT: return is_digit(c) ? LX_FRAC : LX_MAL;
            LX_FRAC: begin
                if (is_digit(c)) return LX_FRAC;
                if (is_expch(c)) return LX_EXP;
                return end_st;
            end
            LX_EXP: begin
                if (c == CH_PLUS || c == CH_MINUS) return LX_EXPSIGN;
                return is_digit(c) ? LX_EXPDIG : LX_MAL;
            end
            LX_EXPSIGN: return is_digit(c) ? LX_EXPDIG : LX_MAL;
            LX_EXPDIG: begin
                if (is_digit(c)) return LX_EXPDIG;
                return end_st;
            end
            default: begin
                if (c == CH_0) return LX_ZERO;
                if (is_digit(c)) return LX_DEC;
                return is_space(c) ? LX_WS : LX_MAL;
            end
        endcase
    endfunction

    // advance the lexer by one character and queue the report it causes
    function automatic void lex_char(input t_in_item it);
        lex_state_e nxt;
        t_out_item  rep;
        bit         fire;
        nxt  = next_lex(lex_st, it.char_code);
        rep  = '0;
        fire = 1'b0;
        if (nxt == LX_MAL) begin
            fire       = 1'b1;
            rep.status = STATUS_MAL;
        end else if (nxt == LX_BAD) begin
            fire             = 1'b1;
            rep.status       = STATUS_BAD;
            rep.token_kind   = kind_of(lex_st);
            rep.token_length = tok_len;
        end else if (nxt == LX_WS) begin
            if (is_accepting(lex_st)) begin
                fire             = 1'b1;
                rep.status       = STATUS_CLEAN;
                rep.token_kind   = kind_of(lex_st);
                rep.token_length = tok_len;
            end
            lex_st  = LX_IDLE;
            tok_len = '0;
        end else begin
            lex_st = nxt;
            if (tok_len < LEN_CAP) tok_len = tok_len + 8'd1;
            if (it.last_char) begin
                fire = 1'b1;
                if (is_accepting(nxt)) begin
                    rep.status       = STATUS_CLEAN;
                    rep.token_kind   = kind_of(nxt);
                    rep.token_length = tok_len;
                end else begin
                    rep.status = STATUS_MAL;
                end
            end
        end
        if (fire) begin
            report_q.push_back(rep);
            lex_st  = LX_IDLE;
            tok_len = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            lex_st  = LX_IDLE;
            tok_len = '0;
            report_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (report_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected item: status %0d kind %0d length %0d",
                                 i_out_item.status, i_out_item.token_kind,
                                 i_out_item.token_length);
                end else begin
                    want = report_q.pop_front();
                    if (want.status !== i_out_item.status ||
                        want.token_kind !== i_out_item.token_kind ||
                        want.token_length !== i_out_item.token_length) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= MAX_REPORTS)
                            $display("mismatch: expected status %0d kind %0d length %0d, got status %0d kind %0d length %0d",
                                     want.status, want.token_kind, want.token_length,
                                     i_out_item.status, i_out_item.token_kind,
                                     i_out_item.token_length);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) lex_char(i_in_item);
        end
        o_errors  <= err_cnt;
        o_pending <= report_q.size();
    end

endmodule

@@ tb/tb_numeric_literal_lexer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_numeric_literal_lexer_top
// Feeds the lexer a directed character stream and then random literals,
// broken literals and noise, with phases of idling and stalling on both
// sides; a checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_numeric_literal_lexer_top;
    import nll_pkg::*;

    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_1     = "1";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_LX    = "x";
    localparam logic [7:0] CH_UX    = "X";
    localparam logic [7:0] CH_LE    = "e";
    localparam logic [7:0] CH_UE    = "E";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'd9;

    localparam int DIG_DEC = 0;
    localparam int DIG_OCT = 1;
    localparam int DIG_HEX = 2;

    localparam int LIT_ZERO  = 0;
    localparam int LIT_OCT   = 1;
    localparam int LIT_HEX   = 2;
    localparam int LIT_DEC   = 3;
    localparam int LIT_FRAC  = 4;
    localparam int LIT_FRAC0 = 5;
    localparam int LIT_EXP   = 6;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SEND = 2'd1;
    localparam logic [1:0] MODE_RECV = 2'd2;
    localparam logic [1:0] MODE_BOTH = 2'd3;

    localparam int N_ITEMS     = 1750;
    localparam int MODE_SPAN   = 150;
    localparam int HOLD_AT     = 500;
    localparam int LONG_HOLD   = 200;
    localparam int PAUSE_AT    = 1000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TIMEOUT_NS  = 3_000_000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    int         errors;
    int         pending;

    logic [1:0] idle_mode = MODE_NONE;
    int         sent_cnt  = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    t_in_item   char_q[$];
    logic [7:0] tok[$];

    numeric_literal_lexer_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    numeric_literal_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_numeric_literal_lexer_top: errors");
        $finish;
    end

    task automatic add_char(input logic [7:0] c, input logic lst);
        t_in_item it;
        it.char_code = c;
        it.last_char = lst;
        char_q.push_back(it);
    endtask

    task automatic push_text(input string s, input logic lst);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], lst && (i == s.len() - 1));
    endtask

    task automatic flush_tok(input logic lst);
        for (int i = 0; i < tok.size(); i++)
            add_char(tok[i], lst && (i == tok.size() - 1));
        tok.delete();
    endtask

    function automatic logic [7:0] rnd_space();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    task automatic add_digits(input int n, input int sel);
        int r;
        for (int i = 0; i < n; i++) begin
            case (sel)
                DIG_OCT: tok.push_back(CH_0 + 8'($urandom_range(7)));
                DIG_HEX: begin
                    r = $urandom_range(21);
                    if (r < 10)      tok.push_back(CH_0 + 8'(r));
                    else if (r < 16) tok.push_back(CH_LA + 8'(r - 10));
                    else             tok.push_back(CH_UA + 8'(r - 16));
                end
                default: tok.push_back(CH_0 + 8'($urandom_range(9)));
            endcase
        end
    endtask

    task automatic add_exp();
        int r;
        tok.push_back($urandom_range(1) ? CH_LE : CH_UE);
        r = $urandom_range(2);
        if (r == 1) tok.push_back(CH_PLUS);
        if (r == 2) tok.push_back(CH_MINUS);
        add_digits($urandom_range(3, 1), DIG_DEC);
    endtask

    task automatic gen_literal(input int n, input int kind);
        case (kind)
            LIT_ZERO: tok.push_back(CH_0);
            LIT_OCT: begin
                tok.push_back(CH_0);
                add_digits(n, DIG_OCT);
            end
            LIT_HEX: begin
                tok.push_back(CH_0);
                tok.push_back($urandom_range(1) ? CH_LX : CH_UX);
                add_digits(n, DIG_HEX);
            end
            LIT_DEC: begin
                tok.push_back(CH_1 + 8'($urandom_range(8)));
                add_digits(n - 1, DIG_DEC);
            end
            LIT_FRAC: begin
                tok.push_back(CH_1 + 8'($urandom_range(8)));
                add_digits($urandom_range(2), DIG_DEC);
                tok.push_back(CH_DOT);
                add_digits(n, DIG_DEC);
                if ($urandom_range(1)) add_exp();
            end
            LIT_FRAC0: begin
                tok.push_back(CH_0);
                tok.push_back(CH_DOT);
                add_digits(n, DIG_DEC);
                if ($urandom_range(1)) add_exp();
            end
            default: begin
                tok.push_back(CH_1 + 8'($urandom_range(8)));
                add_digits($urandom_range(2), DIG_DEC);
                add_exp();
            end
        endcase
    endtask

    // close the pending token with whitespace, a random character or the end
    task automatic end_token();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            flush_tok(1'b0);
            add_char(rnd_space(), $urandom_range(9) == 0);
        end else if (r < 80) begin
            flush_tok(1'b0);
            add_char(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
            flush_tok(1'b1);
        end
    endtask

    // receiver: random stalls per mode, plus one long hold-off
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else if (idle_mode == MODE_RECV) begin
            out_stall <= ($urandom_range(99) < 54);
        end else if (idle_mode == MODE_BOTH) begin
            out_stall <= ($urandom_range(99) < 15);
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin : stimulus
        int         idx;
        int         r;
        int         drain;
        int         pct;
        bit         paused;
        logic [1:0] mode;

        // directed: each literal kind, bad char, malformed, high char, both ends
        push_text("0 07\t0xF 1.5E-2 0.3q z 8", 1'b0);
        add_char(8'hC0, 1'b0);
        push_text(" 0x", 1'b1);
        push_text("5", 1'b1);

        // one long token to hit length saturation
        gen_literal(280, LIT_DEC);
        end_token();

        while (char_q.size() < N_ITEMS) begin
            r = $urandom_range(99);
            if (r < 75) begin
                if ($urandom_range(119) == 0)
                    gen_literal($urandom_range(300, 250), $urandom_range(LIT_EXP));
                else
                    gen_literal($urandom_range(5, 1), $urandom_range(LIT_EXP));
                end_token();
            end else if (r < 88) begin
                case ($urandom_range(4))
                    0: begin
                        tok.push_back(CH_0);
                        tok.push_back($urandom_range(1) ? CH_LX : CH_UX);
                    end
                    1: begin
                        tok.push_back(CH_1 + 8'($urandom_range(8)));
                        tok.push_back(CH_DOT);
                    end
                    2: begin
                        tok.push_back(CH_0);
                        tok.push_back(CH_DOT);
                    end
                    3: begin
                        tok.push_back(CH_1 + 8'($urandom_range(8)));
                        tok.push_back($urandom_range(1) ? CH_LE : CH_UE);
                    end
                    default: begin
                        tok.push_back(CH_1 + 8'($urandom_range(8)));
                        tok.push_back(CH_LE);
                        tok.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                    end
                endcase
                end_token();
            end else begin
                repeat ($urandom_range(4, 1))
                    add_char(8'($urandom_range(255)), $urandom_range(7) == 0);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        idx    = 0;
        paused = 1'b0;
        while (idx < char_q.size()) begin
            mode = 2'((idx / MODE_SPAN) % 4);
            pct  = (mode == MODE_SEND) ? 54 : (mode == MODE_BOTH) ? 15 : 0;
            if (idx == PAUSE_AT && !paused) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end else if ($urandom_range(99) < pct) begin
                in_valid  <= 1'b0;
                idle_mode <= mode;
                @(posedge clk);
            end else begin
                in_valid  <= 1'b1;
                in_item   <= char_q[idx];
                idle_mode <= mode;
                @(posedge clk);
                while (in_stall) @(posedge clk);
                idx = idx + 1;
                sent_cnt <= idx;
            end
        end
        in_valid  <= 1'b0;
        idle_mode <= MODE_NONE;
        @(posedge clk);

        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain = drain + 1;
        end
        repeat (10) @(posedge clk);

        if (errors == 0 && pending == 0) begin
            $display("tb_numeric_literal_lexer_top: clean");
        end else begin
            $display("tb_numeric_literal_lexer_top: errors");
        end
        $finish;
    end

endmodule
